>>> rtl/core/rgc_pkg.sv
`default_nettype none
package rgc_pkg;

  // Curve mode codes; the spare code runs as basic mode
  localparam logic [1:0] MODE_BASIC = 2'd0;
  localparam logic [1:0] MODE_FWD   = 2'd1;
  localparam logic [1:0] MODE_REV   = 2'd2;

  // Register map
  localparam int         CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE  = 3'd5;

  localparam logic [63:0] UNITY_X4 = 64'h1000_1000_1000_1000;

  // Power function sizing
  localparam int LOG_STEPS = 16;
  localparam int EXP_STEPS = 16;
  localparam logic [46:0] POW_CAP = '1;
  // base, search, normalize, log steps, mul, decode, exp steps, shift, two scale stages
  localparam int PIPE_DEPTH = 3 + LOG_STEPS + 2 + EXP_STEPS + 3;

  // Per-channel settings handed to a lane
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] expo;
    logic [15:0] scale;
    logic [15:0] slope;
    logic [15:0] offset;
    logic [15:0] brk;
  } rgc_chan_cfg_t;

  // Bitwise integer square root, elaboration use only
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bv;
    logic [63:0] rem;
    res = '0;
    bv  = 64'h4000_0000_0000_0000;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bv) begin
        rem = rem - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // 2^(2^-(k+1)) in Q30
  function automatic logic [31:0] exp_factor(input int k);
    logic [63:0] c;
    c = int_sqrt(64'h2000_0000_0000_0000);
    for (int i = 0; i < k; i++) begin
      c = int_sqrt(c << 30);
    end
    return c[31:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/rgc_if.sv
`default_nettype none
// Pixel input channel
interface rgc_in_if #(parameter int SW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] red_in;
  logic signed [SW-1:0] green_in;
  logic signed [SW-1:0] blue_in;
  logic signed [SW-1:0] alpha_in;
  logic                 frame_end_in;
  modport source(output valid, red_in, green_in, blue_in, alpha_in, frame_end_in,
                 input ready);
  modport sink(input valid, red_in, green_in, blue_in, alpha_in, frame_end_in,
               output ready);
endinterface

// Pixel result channel
interface rgc_out_if #(parameter int SW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] red_out;
  logic signed [SW-1:0] green_out;
  logic signed [SW-1:0] blue_out;
  logic signed [SW-1:0] alpha_out;
  logic                 frame_end_out;
  modport source(output valid, red_out, green_out, blue_out, alpha_out, frame_end_out,
                 input ready);
  modport sink(input valid, red_out, green_out, blue_out, alpha_out, frame_end_out,
               output ready);
endinterface

// Register write channel
interface rgc_cfg_if;
  import rgc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [63:0]          data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/rgc_lane.sv
`default_nettype none
module rgc_lane #(
  parameter int SW = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  rgc_pkg::rgc_chan_cfg_t cfg,
  input  logic signed [SW-1:0]   x,
  output logic signed [SW-1:0]   y
);
  import rgc_pkg::*;

  localparam int F  = SW - 3;
  localparam int AW = ((SW > 16) ? SW : 16) + 1;
  localparam int PW = SW + 17;
  localparam int BW = SW + 18;
  localparam int UB = BW - 1;
  localparam int PB = $clog2(UB);
  localparam int QW = 42;
  localparam int TW = 53;
  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [46:0] SMAX_U = 47'((64'd1 << (SW - 1)) - 64'd1);
  localparam logic [46:0] ONE_U  = 47'(64'd1 << F);
  localparam logic signed [QW-1:0] Q_BIAS = QW'(F) <<< 28;
  localparam logic signed [QW-1:0] Q_TOP  = QW'(47) <<< 28;
  localparam int S_LOG0 = 2;
  localparam int S_EXP0 = S_LOG0 + LOG_STEPS + 2;

  typedef struct packed {
    logic                 islin;
    logic                 pos;
    logic signed [SW-1:0] lin;
  } side_t;

  // Offset and break aligned to the sample fraction
  logic signed [AW-1:0] off_al;
  logic signed [AW-1:0] brk_al;
  generate
    if (F >= 13) begin : g_up
      assign off_al = AW'($signed(cfg.offset)) <<< (F - 13);
      assign brk_al = AW'($signed(cfg.brk)) <<< (F - 13);
    end else begin : g_dn
      assign off_al = AW'($signed(cfg.offset)) >>> (13 - F);
      assign brk_al = AW'($signed(cfg.brk)) >>> (13 - F);
    end
  endgenerate

  side_t sd_r [PIPE_DEPTH];

  // Stage 0: linear segment and power base
  logic signed [PW-1:0] lin_p;
  logic signed [PW-1:0] lin_s;
  logic signed [PW-1:0] sc_p;
  logic signed [BW-1:0] base_nxt;
  side_t                sd_nxt;
  logic signed [BW-1:0] base_r;

  always_comb begin
    lin_p = x * $signed({1'b0, cfg.slope});
    lin_s = lin_p >>> 12;
    sc_p  = x * $signed({1'b0, cfg.scale});
    if (cfg.mode == MODE_FWD) begin
      base_nxt = BW'(sc_p >>> 12) + BW'(off_al);
    end else if (cfg.mode == MODE_REV) begin
      base_nxt = BW'(x);
    end else begin
      base_nxt = (x > 0) ? BW'(x) : '0;
    end
    sd_nxt.islin = ((cfg.mode == MODE_FWD) || (cfg.mode == MODE_REV)) &&
                   (AW'(x) <= brk_al);
    sd_nxt.pos   = (base_nxt > 0);
    if (lin_s > PW'(SMAX)) begin
      sd_nxt.lin = SMAX;
    end else if (lin_s < PW'(SMIN)) begin
      sd_nxt.lin = SMIN;
    end else begin
      sd_nxt.lin = lin_s[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base_r   <= base_nxt;
      sd_r[0]  <= sd_nxt;
      for (int s = 1; s < PIPE_DEPTH; s++) begin
        sd_r[s] <= sd_r[s-1];
      end
    end
  end

  // Stage 1: leading one search
  logic [PB-1:0] p_nxt;
  logic [UB-1:0] b1_r;
  logic [PB-1:0] p1_r;
  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < UB; i++) begin
      if (base_r[i]) p_nxt = PB'(i);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b1_r <= base_r[UB-1:0];
      p1_r <= p_nxt;
    end
  end

  // Stage 2: normalize mantissa to [1,2) in Q30
  logic [UB+29:0] norm_w;
  logic [30:0]    m_r  [LOG_STEPS+1];
  logic [15:0]    fr_r [LOG_STEPS+1];
  logic [PB-1:0]  lp_r [LOG_STEPS+1];
  assign norm_w = {b1_r, 30'b0} >> p1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]  <= norm_w[30:0];
      fr_r[0] <= '0;
      lp_r[0] <= p1_r;
    end
  end

  // Log2 fraction, one bit per squaring stage
  generate
    for (genvar k = 0; k < LOG_STEPS; k++) begin : g_log
      logic [61:0] sq;
      logic [31:0] m2;
      assign sq = 62'(m_r[k]) * 62'(m_r[k]);
      assign m2 = sq[61:30];
      always_ff @(posedge clk) begin
        if (en) begin
          m_r[k+1]  <= m2[31] ? m2[31:1] : m2[30:0];
          fr_r[k+1] <= {fr_r[k][14:0], m2[31]};
          lp_r[k+1] <= lp_r[k];
        end
      end
    end
  endgenerate

  // Exponent times log2
  logic signed [7:0]    pf;
  logic signed [23:0]   l2;
  logic signed [QW-1:0] q_r;
  assign pf = $signed(8'(lp_r[LOG_STEPS])) - 8'sd0 - $signed(8'(F));
  assign l2 = {pf, fr_r[LOG_STEPS]};
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= QW'(l2) * QW'($signed({1'b0, cfg.expo})) + Q_BIAS;
    end
  end

  // Split into integer and fraction of the power
  logic [31:0] r_r   [EXP_STEPS+1];
  logic [15:0] f_r   [EXP_STEPS+1];
  logic [5:0]  n_r   [EXP_STEPS+1];
  logic        neg_r [EXP_STEPS+1];
  logic        cap_r [EXP_STEPS+1];
  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= 32'h4000_0000;
      f_r[0]   <= q_r[27:12];
      n_r[0]   <= q_r[33:28];
      neg_r[0] <= q_r[QW-1];
      cap_r[0] <= !q_r[QW-1] && (q_r >= Q_TOP);
    end
  end

  // Exp2 fraction, one factor per stage
  generate
    for (genvar k = 0; k < EXP_STEPS; k++) begin : g_exp
      localparam logic [31:0] C = exp_factor(k);
      logic [63:0] prod;
      assign prod = 64'(r_r[k]) * 64'(C);
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[k+1]   <= f_r[k][15-k] ? prod[61:30] : r_r[k];
          f_r[k+1]   <= f_r[k];
          n_r[k+1]   <= n_r[k];
          neg_r[k+1] <= neg_r[k];
          cap_r[k+1] <= cap_r[k];
        end
      end
    end
  endgenerate

  // Integer part of the power as a shift, with the special cases
  logic [48:0] sh_w;
  logic [46:0] pw_nxt;
  logic [46:0] pw_r;
  assign sh_w = {r_r[EXP_STEPS], 17'b0} >> (6'd47 - n_r[EXP_STEPS]);
  always_comb begin
    if (!sd_r[S_EXP0 + EXP_STEPS].pos) begin
      pw_nxt = (cfg.expo == 16'd0) ? ONE_U : '0;
    end else if (neg_r[EXP_STEPS]) begin
      pw_nxt = '0;
    end else if (cap_r[EXP_STEPS]) begin
      pw_nxt = POW_CAP;
    end else begin
      pw_nxt = sh_w[46:0];
    end
  end
  always_ff @(posedge clk) begin
    if (en) pw_r <= pw_nxt;
  end

  // Scale partial products and clamped power
  logic [39:0]          pl_r;
  logic [38:0]          ph_r;
  logic signed [SW-1:0] pwc_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pl_r  <= 40'(pw_r[23:0]) * 40'(cfg.scale);
      ph_r  <= 39'(pw_r[46:24]) * 39'(cfg.scale);
      pwc_r <= (pw_r > SMAX_U) ? SMAX : $signed(pw_r[SW-1:0]);
    end
  end

  // Final select and saturation
  logic [62:0]          sum_w;
  logic signed [TW-1:0] t_w;
  logic signed [SW-1:0] tc;
  logic signed [SW-1:0] y_r;
  always_comb begin
    sum_w = 63'(pl_r) + (63'(ph_r) << 24);
    t_w   = $signed({2'b00, sum_w[62:12]}) - TW'(off_al);
    if (t_w > TW'(SMAX)) begin
      tc = SMAX;
    end else if (t_w < TW'(SMIN)) begin
      tc = SMIN;
    end else begin
      tc = t_w[SW-1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (sd_r[PIPE_DEPTH-2].islin) begin
        y_r <= sd_r[PIPE_DEPTH-2].lin;
      end else if (cfg.mode == MODE_REV) begin
        y_r <= tc;
      end else begin
        y_r <= pwc_r;
      end
    end
  end
  assign y = y_r;

endmodule
`default_nettype wire

>>> rtl/core/rgba_gamma_curve_top.sv
`default_nettype none
// RGBA gamma / monitor-curve transfer. One pixel is taken per clock while the
// output is not stalled. The per-channel lanes each run a 16-stage log2 squaring
// chain and a 16-stage exp2 product chain with one multiplier per stage. A stalled
// output holds the whole pipeline. Registers are written through the cfg port,
// which is always ready; the user must write them only while no pixel is in
// flight, as the block itself does not enforce this. Channels at CHANNELS and
// above pass through with the same latency.
module rgba_gamma_curve_top #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int CHANNELS     = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  rgc_in_if.sink           in_px,
  rgc_out_if.source        out_px,
  rgc_cfg_if.sink          cfg_wr
);
  import rgc_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int L  = PIPE_DEPTH;

  // Configuration registers
  logic [1:0]  mode_r;
  logic [63:0] expo_r;
  logic [63:0] scale_r;
  logic [63:0] offset_r;
  logic [63:0] brk_r;
  logic [63:0] slope_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_BASIC;
      expo_r   <= UNITY_X4;
      scale_r  <= UNITY_X4;
      offset_r <= '0;
      brk_r    <= '0;
      slope_r  <= UNITY_X4;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_MODE:   mode_r   <= cfg_wr.data[1:0];
        REG_EXP:    expo_r   <= cfg_wr.data;
        REG_SCALE:  scale_r  <= cfg_wr.data;
        REG_OFFSET: offset_r <= cfg_wr.data;
        REG_BREAK:  brk_r    <= cfg_wr.data;
        REG_SLOPE:  slope_r  <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // Pipeline flow: advance unless the output holds an untaken transfer
  logic         en;
  logic [L-1:0] vld_r;
  logic [L-1:0] fe_r;
  assign en          = !vld_r[L-1] || out_px.ready;
  assign in_px.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[L-2:0], in_px.valid};
    end
  end
  always_ff @(posedge clk) begin
    if (en) fe_r <= {fe_r[L-2:0], in_px.frame_end_in};
  end

  // Lanes
  logic signed [SW-1:0] xin  [4];
  logic signed [SW-1:0] yout [4];
  assign xin[0] = in_px.red_in;
  assign xin[1] = in_px.green_in;
  assign xin[2] = in_px.blue_in;
  assign xin[3] = in_px.alpha_in;

  generate
    for (genvar c = 0; c < 4; c++) begin : g_ch
      if (c < CHANNELS) begin : g_lane
        rgc_chan_cfg_t ccfg;
        assign ccfg.mode   = mode_r;
        assign ccfg.expo   = expo_r[16*c +: 16];
        assign ccfg.scale  = scale_r[16*c +: 16];
        assign ccfg.slope  = slope_r[16*c +: 16];
        assign ccfg.offset = offset_r[16*c +: 16];
        assign ccfg.brk    = brk_r[16*c +: 16];
        rgc_lane #(.SW(SW)) u_lane (
          .clk (clk),
          .en  (en),
          .cfg (ccfg),
          .x   (xin[c]),
          .y   (yout[c])
        );
      end else begin : g_pass
        logic signed [SW-1:0] dl_r [L];
        always_ff @(posedge clk) begin
          if (en) begin
            dl_r[0] <= xin[c];
            for (int s = 1; s < L; s++) begin
              dl_r[s] <= dl_r[s-1];
            end
          end
        end
        assign yout[c] = dl_r[L-1];
      end
    end
  endgenerate

  // Merge lanes onto the result channel
  assign out_px.valid         = vld_r[L-1];
  assign out_px.red_out       = yout[0];
  assign out_px.green_out     = yout[1];
  assign out_px.blue_out      = yout[2];
  assign out_px.alpha_out     = yout[3];
  assign out_px.frame_end_out = fe_r[L-1];

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import rgc_pkg::*;

  typedef struct packed {
    logic signed [15:0] red;
    logic signed [15:0] green;
    logic signed [15:0] blue;
    logic signed [15:0] alpha;
    logic               frame_end;
  } pixel_t;

  // Gamma-curve predictor and queue of expected pixels
  class curve_scoreboard;
    logic [1:0]  mode_reg;
    logic [63:0] expo_reg, scale_reg, offset_reg, break_reg, slope_reg;
    pixel_t      pending_px[$];
    int          mismatches;

    function new();
      mode_reg   = MODE_BASIC;
      expo_reg   = UNITY_X4;
      scale_reg  = UNITY_X4;
      offset_reg = '0;
      break_reg  = '0;
      slope_reg  = UNITY_X4;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
      case (idx)
        REG_MODE:   mode_reg   = val[1:0];
        REG_EXP:    expo_reg   = val;
        REG_SCALE:  scale_reg  = val;
        REG_OFFSET: offset_reg = val;
        REG_BREAK:  break_reg  = val;
        REG_SLOPE:  slope_reg  = val;
        default: ;
      endcase
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned res, bv;
      res = 0;
      bv  = 64'h4000_0000_0000_0000;
      while (bv > v) bv = bv >> 2;
      while (bv != 0) begin
        if (v >= res + bv) begin
          v   = v - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
        bv = bv >> 2;
      end
      return res;
    endfunction

    // base (13 fraction bits) to the power e (Q4.12), log2 then exp2
    function longint unsigned power(longint base, longint e);
      longint unsigned b, m, r, c, f;
      longint          l2, q, frac;
      int              p, n;
      if (base <= 0) return (e == 0) ? 64'd8192 : 64'd0;
      b = base;
      p = 63;
      while (b[p] == 1'b0) p--;
      m = (p <= 30) ? (b << (30 - p)) : (b >> (p - 30));
      frac = 0;
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= 64'h8000_0000) begin
          m = m >> 1;
          frac = frac | 1;
        end
      end
      l2 = longint'(p - 13) * 65536 + frac;
      q  = l2 * e + 64'sd13 * (64'sd1 <<< 28);
      if (q < 0) return 0;
      if (q >= (64'sd47 <<< 28)) return {17'd0, POW_CAP};
      n = int'(q >>> 28);
      f = (q >>> 12) & 64'hFFFF;
      r = 64'd1 << 30;
      c = isqrt(64'd1 << 61);
      for (int k = 0; k < 16; k++) begin
        if (f[15-k]) r = (r * c) >> 30;
        c = isqrt(c << 30);
      end
      return (n >= 30) ? (r << (n - 30)) : (r >> (30 - n));
    endfunction

    function logic signed [15:0] sat16(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    function logic signed [15:0] curve(logic signed [15:0] sample, int ch);
      longint x, e, sc, sl, off, brk, base, t;
      longint unsigned pw;
      x   = sample;
      e   = expo_reg[16*ch +: 16];
      sc  = scale_reg[16*ch +: 16];
      sl  = slope_reg[16*ch +: 16];
      off = $signed(offset_reg[16*ch +: 16]);
      brk = $signed(break_reg[16*ch +: 16]);
      if (mode_reg == MODE_FWD || mode_reg == MODE_REV) begin
        if (x <= brk) return sat16((x * sl) >>> 12);
        if (mode_reg == MODE_FWD) begin
          base = ((x * sc) >>> 12) + off;
          return sat16(longint'(power(base, e)));
        end
        pw = power(x, e);
        t  = longint'((pw * longint'(sc)) >> 12) - off;
        return sat16(t);
      end
      return sat16(longint'(power(x > 0 ? x : 0, e)));
    endfunction

    function void note_pixel(pixel_t px);
      pixel_t exp_px;
      exp_px.red       = curve(px.red, 0);
      exp_px.green     = curve(px.green, 1);
      exp_px.blue      = curve(px.blue, 2);
      exp_px.alpha     = curve(px.alpha, 3);
      exp_px.frame_end = px.frame_end;
      pending_px.push_back(exp_px);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel out: %p", got);
        return;
      end
      want = pending_px.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch: exp r=%h g=%h b=%h a=%h fe=%b act r=%h g=%h b=%h a=%h fe=%b",
                   want.red, want.green, want.blue, want.alpha, want.frame_end,
                   got.red, got.green, got.blue, got.alpha, got.frame_end);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_idle;
  int   cycles;
  curve_scoreboard sb;

  rgc_in_if  #(.SW(16)) in_bus();
  rgc_out_if #(.SW(16)) out_bus();
  rgc_cfg_if            cfg_bus();

  rgba_gamma_curve_top #(.SAMPLE_WIDTH(16), .CHANNELS(4)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_px(in_bus.sink), .out_px(out_bus.source), .cfg_wr(cfg_bus.sink)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 600000) begin
        $display("rgba_gamma_curve_top test failed");
        $finish;
      end
    end
  end

  // Monitor: note every transfer on all three channels
  always @(posedge clk) begin
    pixel_t px;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) sb.write_reg(cfg_bus.index, cfg_bus.data);
      if (in_bus.valid && in_bus.ready) begin
        px = {in_bus.red_in, in_bus.green_in, in_bus.blue_in, in_bus.alpha_in,
              in_bus.frame_end_in};
        sb.note_pixel(px);
      end
      if (out_bus.valid && out_bus.ready) begin
        px = {out_bus.red_out, out_bus.green_out, out_bus.blue_out, out_bus.alpha_out,
              out_bus.frame_end_out};
        sb.check_pixel(px);
      end
    end
  end

  // Sink backpressure
  always @(negedge clk) begin
    out_bus.ready = no_idle ? 1'b1 : ($urandom_range(99) >= 9);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic send_pixel(pixel_t px);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 9) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid        = 1'b1;
    in_bus.red_in       = px.red;
    in_bus.green_in     = px.green;
    in_bus.blue_in      = px.blue;
    in_bus.alpha_in     = px.alpha;
    in_bus.frame_end_in = px.frame_end;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Drop valid and let the pipeline empty before touching registers
  task automatic drain();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 5) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(9))
      0, 1, 2: return 16'($urandom());
      3:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 16'h2400));
    endcase
  endfunction

  function automatic logic [15:0] rand_q412();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom());
      default: return 16'($urandom_range(16'h0400, 16'h3000));
    endcase
  endfunction

  function automatic logic [15:0] rand_q213();
    case ($urandom_range(7))
      0:       return 16'($urandom());
      1:       return 16'h0000;
      default: return 16'(int'($urandom_range(0, 16'h1000)) - 16'h0800);
    endcase
  endfunction

  function automatic logic [63:0] pack4(bit is_q412);
    logic [63:0] v;
    for (int c = 0; c < 4; c++) v[16*c +: 16] = is_q412 ? rand_q412() : rand_q213();
    return v;
  endfunction

  task automatic random_pixels(int n);
    pixel_t px;
    for (int i = 0; i < n; i++) begin
      px = {rand_sample(), rand_sample(), rand_sample(), rand_sample(),
            1'($urandom_range(15) == 0)};
      send_pixel(px);
    end
  endtask

  initial begin
    logic [15:0] corner[8];
    pixel_t      px;
    sb = new();
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.red_in = '0;
    in_bus.green_in = '0;
    in_bus.blue_in = '0;
    in_bus.alpha_in = '0;
    in_bus.frame_end_in = 1'b0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_MODE;
    cfg_bus.data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed corners at reset settings, then with zero, minimum, 8.0 and max exponents
    corner = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h2000, 16'h0800,
               16'h1FFF};
    for (int i = 0; i < 8; i++) begin
      px = {corner[i], corner[7-i], corner[(i+3)%8], corner[(i+5)%8], 1'(i == 7)};
      send_pixel(px);
    end
    drain();
    write_reg(REG_EXP, 64'hFFFF_0000_0001_8000);
    for (int i = 0; i < 8; i++) begin
      px = {corner[i], corner[i], corner[i], corner[i], 1'(i[0])};
      send_pixel(px);
    end
    drain();

    // Curve phases: basic, forward and reverse, samples around the forward and reverse break points, spare mode
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(REG_MODE, (ph == 8) ? 64'd3 : 64'(ph % 3));
      write_reg(REG_EXP, (ph == 7) ? 64'hFFFF_FFFF_0000_0000 : pack4(1'b1));
      write_reg(REG_SCALE, (ph == 7) ? 64'hFFFF_0000_FFFF_0000 : pack4(1'b1));
      write_reg(REG_OFFSET, (ph == 6) ? 64'h7FFF_8000_7FFF_8000 : pack4(1'b0));
      write_reg(REG_BREAK, (ph == 6) ? 64'h8000_7FFF_0000_FFFF : pack4(1'b0));
      write_reg(REG_SLOPE, (ph == 7) ? 64'h0000_FFFF_0000_FFFF : pack4(1'b1));
      if (ph == 1 || ph == 2) begin
        // samples right at and next to each break point
        for (int d = -1; d <= 1; d++) begin
          px.red       = 16'(sb.break_reg[15:0] + d);
          px.green     = 16'(sb.break_reg[31:16] + d);
          px.blue      = 16'(sb.break_reg[47:32] + d);
          px.alpha     = 16'(sb.break_reg[63:48] + d);
          px.frame_end = 1'b0;
          send_pixel(px);
        end
      end
      no_idle = (ph == 4);
      random_pixels(120);
      no_idle = 1'b0;
      drain();
    end

    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_px.size() == 0) begin
      $display("rgba_gamma_curve_top test passed");
    end else begin
      $display("rgba_gamma_curve_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> rgba_gamma_curve_top.f
rtl/core/rgc_pkg.sv
rtl/core/rgc_if.sv
rtl/core/rgc_lane.sv
rtl/core/rgba_gamma_curve_top.sv
dv/tb_top.sv
